[design/jhd_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// JPEG Huffman decoder package
// Shared types and constants for the table loader, the bit decoder and the
// top level.
// ============================================================================
package jhd_pkg;

   // Default sizing.
   localparam int MaxCodeLength = 16;
   localparam int SymbolDepth   = 256;

   // Number of code-length counts in a table definition.
   localparam int CountEntries  = 16;

   // Opcodes of an input beat.
   localparam logic OP_TABLE = 1'b0;
   localparam logic OP_BIT   = 1'b1;

   // Table classes.
   localparam logic CLASS_DC = 1'b0;
   localparam logic CLASS_AC = 1'b1;

   // Largest legal class nibble and largest DC category.
   localparam logic [3:0] ClassMaxCode  = 4'd1;
   localparam logic [7:0] DcMaxCategory = 8'd15;

   // AC symbol that means end of block.
   localparam logic [7:0] SymEob = 8'h00;

   typedef enum logic [2:0] {
      ST_COEF   = 3'd0,
      ST_EOB    = 3'd1,
      ST_DECERR = 3'd2,
      ST_TABERR = 3'd3,
      ST_READY  = 3'd4
   } status_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] table_byte;
      logic       table_last;
      logic       coded_bit;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic [3:0]         zero_run;
      logic signed [15:0] coefficient;
   } rsp_item_type;

   // A result produced by one of the processing units.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

   // Table state that the loader hands to the decoder.
   typedef struct packed {
      logic valid;
      logic tclass;
   } table_state_type;

   // Length counts as one packed vector, entry i holds codes of length i+1.
   typedef logic [CountEntries-1:0][7:0] counts_type;

endpackage

[design/jhd_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// Generic RAM
// One write port and two read ports with registered read data. A read of the
// address being written returns the new data.
// ============================================================================
module jhd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr0,
   input  logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic [WIDTH-1:0]         rd_data0,
   output logic [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= (wr_en && (wr_addr == rd_addr0)) ? wr_data : mem_ff[rd_addr0];
      rd_data1_ff <= (wr_en && (wr_addr == rd_addr1)) ? wr_data : mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

[design/jhd_loader.sv]
`timescale 1ns / 1ps
// ============================================================================
// JPEG Huffman table loader
// Walks the class byte, the sixteen length counts and the symbols of one
// table definition, writes the symbol store and reports ready or error.
// ============================================================================
module jhd_loader #(
   parameter int SYMBOL_DEPTH = jhd_pkg::SymbolDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load_en,
   input  logic [7:0]                      load_byte,
   input  logic                            load_last,
   output jhd_pkg::result_type             load_result,
   output jhd_pkg::table_state_type        table_state,
   output jhd_pkg::counts_type             counts,
   output logic                            ram_wr_en,
   output logic [$clog2(SYMBOL_DEPTH)-1:0] ram_wr_addr,
   output logic [7:0]                      ram_wr_data
);

   localparam int AddrWidth = $clog2(SYMBOL_DEPTH);

   localparam logic [8:0]  PosClass       = 9'd0;
   localparam logic [8:0]  PosFirstCount  = 9'd1;
   localparam logic [8:0]  PosLastCount   = 9'(jhd_pkg::CountEntries);
   localparam logic [8:0]  PosFirstSymbol = 9'(jhd_pkg::CountEntries + 1);
   localparam logic [8:0]  DepthIdx       = 9'(SYMBOL_DEPTH);
   localparam logic [11:0] DepthExp       = 12'(SYMBOL_DEPTH);

   logic [8:0]  pos_ff, pos_in;
   logic [11:0] exp_ff, exp_in;
   logic        class_ff, class_in;
   logic        valid_ff, valid_in;
   jhd_pkg::counts_type counts_ff;

   logic [11:0] exp_sum;
   logic [8:0]  pos_m1;
   logic [8:0]  sym_idx;
   logic [11:0] sym_idx_p1;
   logic        cnt_we;
   logic        fail;
   logic        done;

   assign exp_sum    = exp_ff + {4'b0, load_byte};
   assign pos_m1     = pos_ff - 9'd1;
   assign sym_idx    = pos_ff - PosFirstSymbol;
   assign sym_idx_p1 = {3'b0, sym_idx} + 12'd1;

   always_comb begin
      pos_in      = pos_ff;
      exp_in      = exp_ff;
      class_in    = class_ff;
      valid_in    = valid_ff;
      cnt_we      = 1'b0;
      ram_wr_en   = 1'b0;
      fail        = 1'b0;
      done        = 1'b0;
      load_result = '0;
      if (load_en) begin
         valid_in = 1'b0;
         if (pos_ff == PosClass) begin
            if ((load_byte[7:4] > jhd_pkg::ClassMaxCode) || load_last) begin
               fail = 1'b1;
            end else begin
               class_in = load_byte[4];
               exp_in   = '0;
               pos_in   = PosFirstCount;
            end
         end else if (pos_ff <= PosLastCount) begin
            cnt_we = 1'b1;
            exp_in = exp_sum;
            if (pos_ff < PosLastCount) begin
               if (load_last) begin
                  fail = 1'b1;
               end else begin
                  pos_in = pos_ff + 9'd1;
               end
            end else if (exp_sum > DepthExp) begin
               fail = 1'b1;
            end else if (exp_sum == '0) begin
               done = 1'b1;
            end else if (load_last) begin
               fail = 1'b1;
            end else begin
               pos_in = PosFirstSymbol;
            end
         end else begin
            ram_wr_en = (sym_idx < DepthIdx);
            if (sym_idx_p1 >= exp_ff) begin
               done = 1'b1;
            end else if (load_last) begin
               fail = 1'b1;
            end else begin
               pos_in = pos_ff + 9'd1;
            end
         end
         if (fail) begin
            pos_in                  = PosClass;
            load_result.valid       = 1'b1;
            load_result.item.status = jhd_pkg::ST_TABERR;
         end
         if (done) begin
            pos_in                  = PosClass;
            valid_in                = 1'b1;
            load_result.valid       = 1'b1;
            load_result.item.status = jhd_pkg::ST_READY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= PosClass;
         exp_ff   <= '0;
         class_ff <= jhd_pkg::CLASS_DC;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         exp_ff   <= exp_in;
         class_ff <= class_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         counts_ff[pos_m1[3:0]] <= load_byte;
      end
   end

   assign counts             = counts_ff;
   assign table_state.valid  = valid_ff;
   assign table_state.tclass = class_ff;
   assign ram_wr_addr        = sym_idx[AddrWidth-1:0];
   assign ram_wr_data        = load_byte;

endmodule

[design/jhd_bit_decoder.sv]
`timescale 1ns / 1ps
// ============================================================================
// JPEG Huffman bit decoder
// Decodes canonical codes one bit per enabled cycle, then gathers and sign-extends
// the magnitude bits. The symbol store is read ahead for both possible next bits.
// ============================================================================
module jhd_bit_decoder #(
   parameter int MAX_CODE_LENGTH = jhd_pkg::MaxCodeLength,
   parameter int SYMBOL_DEPTH    = jhd_pkg::SymbolDepth
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear_en,
   input  logic                            bit_en,
   input  logic                            coded_bit,
   input  jhd_pkg::table_state_type        table_state,
   input  jhd_pkg::counts_type             counts,
   input  logic [7:0]                      rd_data0,
   input  logic [7:0]                      rd_data1,
   output logic [$clog2(SYMBOL_DEPTH)-1:0] rd_addr0,
   output logic [$clog2(SYMBOL_DEPTH)-1:0] rd_addr1,
   output jhd_pkg::result_type             dec_result
);

   localparam int          AddrWidth = $clog2(SYMBOL_DEPTH);
   localparam logic [4:0]  MaxLen    = 5'(MAX_CODE_LENGTH);
   localparam logic [9:0]  DepthIdx  = 10'(SYMBOL_DEPTH);

   logic [15:0] acc_ff, acc_in;
   logic [4:0]  len_ff, len_in;
   logic [16:0] fc_ff, fc_in;
   logic [8:0]  so_ff, so_in;
   logic        mag_phase_ff, mag_phase_in;
   logic [3:0]  left_ff, left_in;
   logic [3:0]  total_ff, total_in;
   logic [15:0] raw_ff, raw_in;
   logic [3:0]  run_ff, run_in;

   logic [15:0] acc_new;
   logic [4:0]  len_new;
   logic [7:0]  cnt;
   logic [16:0] diff;
   logic        match;
   logic [9:0]  idx;
   logic [7:0]  sym;
   logic [15:0] raw_new;
   logic [3:0]  left_new;
   logic [3:0]  t_eff;
   logic [3:0]  sign_pos;
   logic [15:0] mag_mask;
   logic [15:0] mag_value;
   logic        do_clear;
   logic        start_mag;
   logic [3:0]  start_size;
   logic [3:0]  start_run;

   assign acc_new = {acc_ff[14:0], coded_bit};
   assign len_new = len_ff + 5'd1;
   assign cnt     = counts[len_ff[3:0]];
   assign diff    = {1'b0, acc_new} - fc_ff;
   assign match   = ({1'b0, acc_new} >= fc_ff) && (diff < {9'b0, cnt});
   assign idx     = {1'b0, so_ff} + {2'b0, diff[7:0]};
   assign sym     = coded_bit ? rd_data1 : rd_data0;

   // Magnitude: a leading zero bit marks a negative value.
   assign raw_new   = {raw_ff[14:0], coded_bit};
   assign left_new  = left_ff - 4'd1;
   assign t_eff     = (total_ff == '0) ? 4'd1 : total_ff;
   assign sign_pos  = t_eff - 4'd1;
   assign mag_mask  = (16'd1 << t_eff) - 16'd1;
   assign mag_value = raw_new[sign_pos] ? raw_new : (raw_new - mag_mask);

   always_comb begin
      acc_in       = acc_ff;
      len_in       = len_ff;
      fc_in        = fc_ff;
      so_in        = so_ff;
      mag_phase_in = mag_phase_ff;
      left_in      = left_ff;
      total_in     = total_ff;
      raw_in       = raw_ff;
      run_in       = run_ff;
      do_clear     = 1'b0;
      start_mag    = 1'b0;
      start_size   = sym[3:0];
      start_run    = '0;
      dec_result   = '0;

      if (clear_en) begin
         do_clear = 1'b1;
      end else if (bit_en) begin
         if (!table_state.valid) begin
            dec_result.valid       = 1'b1;
            dec_result.item.status = jhd_pkg::ST_DECERR;
         end else if (mag_phase_ff) begin
            raw_in  = raw_new;
            left_in = left_new;
            if (left_new == '0) begin
               do_clear                    = 1'b1;
               dec_result.valid            = 1'b1;
               dec_result.item.status      = jhd_pkg::ST_COEF;
               dec_result.item.zero_run    = run_ff;
               dec_result.item.coefficient = mag_value;
            end
         end else if (match) begin
            do_clear = 1'b1;
            if (idx >= DepthIdx) begin
               dec_result.valid       = 1'b1;
               dec_result.item.status = jhd_pkg::ST_DECERR;
            end else if (table_state.tclass == jhd_pkg::CLASS_DC) begin
               if (sym > jhd_pkg::DcMaxCategory) begin
                  dec_result.valid       = 1'b1;
                  dec_result.item.status = jhd_pkg::ST_DECERR;
               end else if (sym[3:0] == '0) begin
                  dec_result.valid       = 1'b1;
                  dec_result.item.status = jhd_pkg::ST_COEF;
               end else begin
                  start_mag = 1'b1;
               end
            end else begin
               start_run = sym[7:4];
               if (sym == jhd_pkg::SymEob) begin
                  dec_result.valid       = 1'b1;
                  dec_result.item.status = jhd_pkg::ST_EOB;
               end else if (sym[3:0] == '0) begin
                  dec_result.valid         = 1'b1;
                  dec_result.item.status   = jhd_pkg::ST_COEF;
                  dec_result.item.zero_run = sym[7:4];
               end else begin
                  start_mag = 1'b1;
               end
            end
         end else if (len_new >= MaxLen) begin
            do_clear               = 1'b1;
            dec_result.valid       = 1'b1;
            dec_result.item.status = jhd_pkg::ST_DECERR;
         end else begin
            acc_in = acc_new;
            len_in = len_new;
            fc_in  = (fc_ff + {9'b0, cnt}) << 1;
            so_in  = so_ff + {1'b0, cnt};
         end
      end

      if (do_clear) begin
         acc_in       = '0;
         len_in       = '0;
         fc_in        = '0;
         so_in        = '0;
         mag_phase_in = 1'b0;
         left_in      = '0;
         total_in     = '0;
         raw_in       = '0;
         run_in       = '0;
      end
      if (start_mag) begin
         mag_phase_in = 1'b1;
         total_in     = start_size;
         left_in      = start_size;
         run_in       = start_run;
      end
   end

   // Read ahead: the next bit picks the entry at this address or the one after.
   assign rd_addr0 = so_in[AddrWidth-1:0] + {acc_in[AddrWidth-2:0], 1'b0}
                     - fc_in[AddrWidth-1:0];
   assign rd_addr1 = rd_addr0 + AddrWidth'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         len_ff       <= '0;
         fc_ff        <= '0;
         so_ff        <= '0;
         mag_phase_ff <= 1'b0;
         left_ff      <= '0;
         total_ff     <= '0;
         raw_ff       <= '0;
         run_ff       <= '0;
      end else begin
         acc_ff       <= acc_in;
         len_ff       <= len_in;
         fc_ff        <= fc_in;
         so_ff        <= so_in;
         mag_phase_ff <= mag_phase_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         raw_ff       <= raw_in;
         run_ff       <= run_in;
      end
   end

endmodule

[design/jpeg_huffman_table_load_and_decode_core.sv]
`timescale 1ns / 1ps
// An accepted input beat waits in the input register, and its result beat, if any,
// is then offered from the result register. Throughput: one input beat per cycle,
// table bytes and coded bits alike, while no result waits with rsp_ready low; the
// symbol store is read ahead for both values of the next bit.
// Reset clears the decoder and the table valid flag; no table is valid until one loads.
// ============================================================================
// JPEG Huffman table load and decode core
// Loads one table in DHT layout and decodes a coded bit stream against it.
// ============================================================================
module jpeg_huffman_table_load_and_decode_core #(
   parameter int MAX_CODE_LENGTH = jhd_pkg::MaxCodeLength,
   parameter int SYMBOL_DEPTH    = jhd_pkg::SymbolDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  jhd_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output jhd_pkg::rsp_item_type rsp_item
);

   localparam int AddrWidth = $clog2(SYMBOL_DEPTH);

   // Input register: one beat waiting to be processed.
   logic                  in_valid_ff, in_valid_in;
   jhd_pkg::req_item_type in_item_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   jhd_pkg::rsp_item_type rsp_item_ff;

   logic advance;
   logic fire;
   logic fire_table;
   logic fire_bit;

   jhd_pkg::result_type      load_result;
   jhd_pkg::result_type      dec_result;
   jhd_pkg::result_type      proc_result;
   jhd_pkg::table_state_type table_state;
   jhd_pkg::counts_type      counts;

   logic                 ram_wr_en;
   logic [AddrWidth-1:0] ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic [AddrWidth-1:0] rd_addr0;
   logic [AddrWidth-1:0] rd_addr1;
   logic [7:0]           rd_data0;
   logic [7:0]           rd_data1;

   // The held beat moves on whenever the result register is free or drains
   // this cycle; a result that waits with rsp_ready low holds back a new beat.
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign fire       = in_valid_ff && advance;
   assign fire_table = fire && (in_item_ff.opcode == jhd_pkg::OP_TABLE);
   assign fire_bit   = fire && (in_item_ff.opcode == jhd_pkg::OP_BIT);
   assign req_ready  = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   jhd_loader #(
      .SYMBOL_DEPTH(SYMBOL_DEPTH)
   ) u_loader (
      .clock       (clock),
      .reset       (reset),
      .load_en     (fire_table),
      .load_byte   (in_item_ff.table_byte),
      .load_last   (in_item_ff.table_last),
      .load_result (load_result),
      .table_state (table_state),
      .counts      (counts),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

   // Symbol store. Entries are only read after the current load wrote them.
   jhd_ram #(
      .WIDTH(8),
      .DEPTH(SYMBOL_DEPTH)
   ) u_symbol_ram (
      .clock    (clock),
      .wr_en    (ram_wr_en),
      .wr_addr  (ram_wr_addr),
      .wr_data  (ram_wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // Any table byte discards a partial decode.
   jhd_bit_decoder #(
      .MAX_CODE_LENGTH(MAX_CODE_LENGTH),
      .SYMBOL_DEPTH   (SYMBOL_DEPTH)
   ) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .clear_en    (fire_table),
      .bit_en      (fire_bit),
      .coded_bit   (in_item_ff.coded_bit),
      .table_state (table_state),
      .counts      (counts),
      .rd_data0    (rd_data0),
      .rd_data1    (rd_data1),
      .rd_addr0    (rd_addr0),
      .rd_addr1    (rd_addr1),
      .dec_result  (dec_result)
   );

   // Only one unit works on a given beat, chosen by its opcode.
   assign proc_result = (in_item_ff.opcode == jhd_pkg::OP_TABLE) ? load_result : dec_result;

   assign rsp_valid_in = advance ? (fire && proc_result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && proc_result.valid) begin
         rsp_item_ff <= proc_result.item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Only coefficient beats carry a run or a value.
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_item.status == jhd_pkg::ST_COEF) ||
                     ((rsp_item.zero_run == '0) && (rsp_item.coefficient == '0))))
      else $error("non-coefficient result carries run or value");

   // A coded bit with no loaded table is reported as a decode error.
   a_no_table : assert property (@(posedge clock) disable iff (reset)
      (fire_bit && !table_state.valid) |=>
         (rsp_valid && (rsp_item.status == jhd_pkg::ST_DECERR)))
      else $error("bit without table not flagged");

   // A held beat is neither lost nor overwritten while the output stalls.
   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held input beat lost");

   // End of block only comes from an AC table.
   a_eob_ac : assert property (@(posedge clock) disable iff (reset)
      (fire_bit && dec_result.valid && (dec_result.item.status == jhd_pkg::ST_EOB))
         |-> (table_state.tclass == jhd_pkg::CLASS_AC))
      else $error("end of block from a DC table");

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// Testbench for the JPEG Huffman table load and decode core
// Loads DHT-style tables and streams coded bits into the core over the
// req/rsp valid-ready channels. A behavioral decoder in this file predicts the
// results the script does not type in; the monitor checks every result beat
// field by field. A short directed script comes first, then table loads and bit
// streams picked at random, with random idle and stall bursts on both channels.
// ============================================================================
module testbench;

   // The script that opens the run. Rows whose result is plain from the
   // table layout carry it typed in; all others go through the predictor.
   typedef struct packed {
      jhd_pkg::req_item_type beat;
      logic                  fixed;
      jhd_pkg::rsp_item_type fixed_rsp;
   } directed_beat_type;

   localparam int   RandomBeats = 700;
   localparam int   TailBeats   = 100;    // last stretch runs with no idling
   localparam int   DrainSlack  = 8;      // extra wait once no result is owed
   localparam int   TimeoutNs   = 2_000_000;
   localparam logic [7:0] SymZeroRun = 8'hF0;

   localparam jhd_pkg::rsp_item_type NoRsp     = '0;
   localparam jhd_pkg::rsp_item_type RspDecErr = '{jhd_pkg::ST_DECERR, 4'd0, 16'sd0};
   localparam jhd_pkg::rsp_item_type RspTabErr = '{jhd_pkg::ST_TABERR, 4'd0, 16'sd0};
   localparam jhd_pkg::rsp_item_type RspReady  = '{jhd_pkg::ST_READY, 4'd0, 16'sd0};
   localparam jhd_pkg::rsp_item_type RspEob    = '{jhd_pkg::ST_EOB, 4'd0, 16'sd0};
   localparam jhd_pkg::rsp_item_type RspZrlMax = '{jhd_pkg::ST_COEF, 4'd15, 16'sd0};

   // The opening script. It hits a bit with no table, an illegal class
   // nibble on an all-ones byte, a last flag that arrives during the counts,
   // and then a two-symbol AC table with codes 0 and 1 that map to end of
   // block and to a sixteen-zero run. The two bits that follow decode both.
   localparam directed_beat_type DirectedBeats [25] = '{
      '{'{jhd_pkg::OP_BIT,   8'h00, 1'b0, 1'b1}, 1'b1, RspDecErr},
      '{'{jhd_pkg::OP_TABLE, 8'hFF, 1'b1, 1'b1}, 1'b1, RspTabErr},
      '{'{jhd_pkg::OP_TABLE, 8'h1F, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b1, 1'b0}, 1'b1, RspTabErr},
      '{'{jhd_pkg::OP_TABLE, 8'h10, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h02, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, 8'h00, 1'b0, 1'b0}, 1'b0, NoRsp},
      '{'{jhd_pkg::OP_TABLE, SymZeroRun, 1'b1, 1'b0}, 1'b1, RspReady},
      '{'{jhd_pkg::OP_BIT,   8'hFF, 1'b1, 1'b0}, 1'b1, RspEob},
      '{'{jhd_pkg::OP_BIT,   8'h00, 1'b0, 1'b1}, 1'b1, RspZrlMax}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   jhd_pkg::req_item_type req_item;
   logic                  rsp_valid;
   logic                  rsp_ready;
   jhd_pkg::rsp_item_type rsp_item;

   // Results the core still owes, oldest first.
   jhd_pkg::rsp_item_type decoded_results_q [$];
   int           mismatch_count = 0;
   int           beats_accepted = 0;

   // Idle controls, changed between episodes of the random part. Once the
   // accepted count comes within the tail of the target, idling stops.
   int           gap_pct     = 10;
   int           stall_pct   = 10;
   int           beat_target = 0;
   logic         tail_phase  = 1'b0;

   // Predictor state: the loaded table and the decoder's progress through
   // the current code or magnitude field.
   logic        tbl_class = jhd_pkg::CLASS_DC;
   logic        tbl_valid = 1'b0;
   logic [7:0]  len_count [jhd_pkg::CountEntries];
   logic [7:0]  sym_mem [jhd_pkg::SymbolDepth];
   int unsigned load_pos  = 0;
   int unsigned sym_total = 0;
   logic [15:0] code_acc   = '0;
   int unsigned code_len   = 0;
   int unsigned code_first = 0;
   int unsigned sym_base   = 0;
   logic        mag_phase  = 1'b0;
   int unsigned mag_left   = 0;
   int unsigned mag_size   = 0;
   logic [15:0] mag_raw    = '0;
   logic [3:0]  run_hold   = '0;

   jpeg_huffman_table_load_and_decode_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Back to the start of a new code.
   function automatic void clear_decoder();
      code_acc   = '0;
      code_len   = 0;
      code_first = 0;
      sym_base   = 0;
      mag_phase  = 1'b0;
      mag_left   = 0;
      mag_size   = 0;
      mag_raw    = '0;
      run_hold   = '0;
   endfunction

   // Advances the predicted decoder by one accepted beat and reports the
   // result beat it causes, if any.
   function automatic void huffman_predict(input jhd_pkg::req_item_type beat,
                                           output logic produced,
                                           output jhd_pkg::rsp_item_type res);
      int unsigned acc;
      int unsigned cnt;
      int unsigned idx;
      int unsigned size;
      logic [7:0]  sym;
      logic [3:0]  run;
      logic [15:0] raw;
      logic        fail;
      logic        done;
      produced = 1'b0;
      res      = NoRsp;
      fail     = 1'b0;
      done     = 1'b0;
      if (beat.opcode == jhd_pkg::OP_TABLE) begin
         // Any table byte drops the current table and any half-decoded code.
         tbl_valid = 1'b0;
         clear_decoder();
         if (load_pos == 0) begin
            fail = (beat.table_byte[7:4] > jhd_pkg::ClassMaxCode) || beat.table_last;
            if (!fail) begin
               tbl_class = beat.table_byte[4];
               sym_total = 0;
            end
         end else if (load_pos <= jhd_pkg::CountEntries) begin
            len_count[load_pos - 1] = beat.table_byte;
            sym_total += beat.table_byte;
            if (load_pos < jhd_pkg::CountEntries) begin
               fail = beat.table_last;
            end else if (sym_total > jhd_pkg::SymbolDepth) begin
               fail = 1'b1;
            end else if (sym_total == 0) begin
               // An empty table is complete right after its counts.
               done = 1'b1;
            end else begin
               fail = beat.table_last;
            end
         end else begin
            idx = load_pos - jhd_pkg::CountEntries - 1;
            sym_mem[idx] = beat.table_byte;
            // The last symbol completes the table whether or not it is flagged.
            done = (idx + 1 >= sym_total);
            fail = !done && beat.table_last;
         end
         if (fail || done) begin
            produced   = 1'b1;
            res.status = done ? jhd_pkg::ST_READY : jhd_pkg::ST_TABERR;
            load_pos   = 0;
            tbl_valid  = done;
         end else begin
            load_pos++;
         end
      end else if (!tbl_valid) begin
         produced   = 1'b1;
         res.status = jhd_pkg::ST_DECERR;
      end else if (mag_phase) begin
         mag_raw = {mag_raw[14:0], beat.coded_bit};
         mag_left--;
         if (mag_left == 0) begin
            // A clear top bit marks a negative value in the JPEG scheme.
            raw = mag_raw;
            if (!raw[mag_size - 1]) begin
               raw = raw - ((16'd1 << mag_size) - 16'd1);
            end
            produced        = 1'b1;
            res.zero_run    = run_hold;
            res.coefficient = raw;
            clear_decoder();
         end
      end else begin
         acc      = {code_acc[14:0], beat.coded_bit};
         code_acc = acc[15:0];
         code_len++;
         cnt = len_count[code_len - 1];
         if (acc >= code_first && acc - code_first < cnt) begin
            idx = sym_base + (acc - code_first);
            clear_decoder();
            produced = 1'b1;
            if (idx >= jhd_pkg::SymbolDepth ||
                (tbl_class == jhd_pkg::CLASS_DC &&
                 sym_mem[idx] > jhd_pkg::DcMaxCategory)) begin
               res.status = jhd_pkg::ST_DECERR;
            end else if (tbl_class == jhd_pkg::CLASS_AC && sym_mem[idx] == jhd_pkg::SymEob) begin
               res.status = jhd_pkg::ST_EOB;
            end else begin
               sym  = sym_mem[idx];
               run  = (tbl_class == jhd_pkg::CLASS_DC) ? 4'd0 : sym[7:4];
               size = (tbl_class == jhd_pkg::CLASS_DC) ? sym : sym[3:0];
               res.zero_run = run;
               // A symbol of size zero is a zero coefficient at once; any
               // other size waits for its magnitude bits.
               if (size != 0) begin
                  produced  = 1'b0;
                  mag_phase = 1'b1;
                  mag_size  = size;
                  mag_left  = size;
                  run_hold  = run;
               end
            end
         end else if (code_len >= jhd_pkg::MaxCodeLength) begin
            produced   = 1'b1;
            res.status = jhd_pkg::ST_DECERR;
            clear_decoder();
         end else begin
            code_first = ((code_first + cnt) << 1) & 32'h1FFFF;
            sym_base   = (sym_base + cnt) & 32'h1FF;
         end
      end
   endfunction

   function automatic jhd_pkg::req_item_type table_beat(input logic [7:0] value,
                                                        input logic last);
      table_beat = '{jhd_pkg::OP_TABLE, value, last, 1'($urandom_range(0, 1))};
   endfunction

   function automatic jhd_pkg::req_item_type bit_beat(input logic value);
      bit_beat = '{jhd_pkg::OP_BIT, 8'($urandom), 1'($urandom_range(0, 1)), value};
   endfunction

   // Offers one beat, holds it until accepted, and books its result. The
   // task starts and ends at a falling edge; valid only drops in an idle
   // burst or a drain, so back-to-back beats keep it high.
   task automatic send_beat(input jhd_pkg::req_item_type beat, input logic fixed,
                            input jhd_pkg::rsp_item_type fixed_rsp);
      logic                  produced;
      jhd_pkg::rsp_item_type predicted;
      tail_phase = (beat_target != 0) && (beats_accepted + TailBeats >= beat_target);
      if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= beat;
      do @(posedge clock); while (!req_ready);
      huffman_predict(beat, produced, predicted);
      if (fixed) begin
         decoded_results_q.push_back(fixed_rsp);
      end else if (produced) begin
         decoded_results_q.push_back(predicted);
      end
      beats_accepted++;
      @(negedge clock);
   endtask

   // Stops sending until every owed result has arrived. Table bytes in the
   // middle of a load cause no result, so a further DrainSlack cycles let the core
   // settle.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (decoded_results_q.size() != 0) @(negedge clock);
      repeat (DrainSlack) @(negedge clock);
   endtask

   // Builds one table definition and sends it. Most are well formed with a
   // prefix-free code; the rest have an illegal class, counts that overflow
   // the symbol store, no codes at all, an early last flag or a stray coded
   // bit in the middle of the load.
   task automatic load_random_table();
      logic [7:0]  dht_bytes [$];
      int unsigned flavor;
      int unsigned space;
      int unsigned budget;
      int unsigned total;
      int unsigned cnt;
      int unsigned cut;
      int unsigned pick;
      int unsigned i;
      logic        last;
      logic [7:0]  sym;
      flavor = $urandom_range(0, 19);
      if (flavor == 0) begin
         send_beat(table_beat({4'($urandom_range(2, 15)), 4'($urandom)},
                              1'($urandom_range(0, 1))), 1'b0, NoRsp);
         return;
      end
      dht_bytes.push_back({3'b000, 1'($urandom_range(0, 1)), 4'($urandom)});
      total  = 0;
      space  = 2;
      budget = (flavor == 2) ? $urandom_range(100, jhd_pkg::SymbolDepth)
                             : $urandom_range(1, 24);
      for (i = 0; i < jhd_pkg::CountEntries; i++) begin
         if (flavor == 1) begin
            cnt = $urandom_range(0, 255);
         end else if (flavor == 3) begin
            cnt = 0;
         end else begin
            // Never hand out more codes than the length still has room for.
            cnt = space;
            if (cnt > budget - total) cnt = budget - total;
            if (cnt > 255) cnt = 255;
            cnt = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, cnt);
            space = (space - cnt) * 2;
         end
         total += cnt;
         dht_bytes.push_back(8'(cnt));
      end
      if (total == 0 && flavor != 3) begin
         dht_bytes[1] = 8'd1;
         total        = 1;
      end
      if (total <= jhd_pkg::SymbolDepth) begin
         for (i = 0; i < total; i++) begin
            pick = $urandom_range(0, 7);
            if (dht_bytes[0][4] == jhd_pkg::CLASS_DC) begin
               sym = (pick == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
            end else begin
               sym = (pick == 0) ? jhd_pkg::SymEob : (pick == 1) ? SymZeroRun : 8'($urandom);
            end
            dht_bytes.push_back(sym);
         end
      end
      cut = dht_bytes.size();
      if ($urandom_range(0, 7) == 0) cut = $urandom_range(1, dht_bytes.size() - 1);
      for (i = 0; i < cut; i++) begin
         if (i > 0 && $urandom_range(0, 63) == 0) begin
            send_beat(bit_beat(1'($urandom_range(0, 1))), 1'b0, NoRsp);
         end
         // The final byte mostly carries the last flag; a truncated load
         // always does.
         last = (i == cut - 1) && (cut < dht_bytes.size() || $urandom_range(0, 4) != 0);
         send_beat(table_beat(dht_bytes[i], last), 1'b0, NoRsp);
      end
   endtask

   // Streams coded bits in runs of zeros, ones or random bits. The constant
   // runs drive long codes and the largest magnitudes of both signs.
   task automatic send_coded_bits(input int unsigned count);
      int unsigned sent;
      int unsigned mode;
      int unsigned run_len;
      int unsigned k;
      logic        value;
      sent = 0;
      while (sent < count) begin
         mode    = $urandom_range(0, 4);
         run_len = $urandom_range(1, 16);
         for (k = 0; k < run_len; k++) begin
            value = (mode == 0) ? 1'b0 : (mode == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            send_beat(bit_beat(value), 1'b0, NoRsp);
         end
         sent += run_len;
      end
   endtask

   // Result side: stalls come in random bursts, none in the tail.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Checks each result beat against the oldest owed result.
   always @(posedge clock) begin
      jhd_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_results_q.size() == 0) begin
            $error("result beat with none owed: status %0d run %0d coefficient %0d",
                   rsp_item.status, rsp_item.zero_run, rsp_item.coefficient);
            mismatch_count++;
         end else begin
            want = decoded_results_q.pop_front();
            if (rsp_item.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_item.status);
               mismatch_count++;
            end
            if (rsp_item.zero_run !== want.zero_run) begin
               $error("zero_run: expected %0d, got %0d", want.zero_run, rsp_item.zero_run);
               mismatch_count++;
            end
            if (rsp_item.coefficient !== want.coefficient) begin
               $error("coefficient: expected %0d, got %0d",
                      want.coefficient, rsp_item.coefficient);
               mismatch_count++;
            end
         end
      end
   end

   // Main sequence: reset, the directed script, then random episodes.
   initial begin
      int row;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < $size(DirectedBeats); row++) begin
         send_beat(DirectedBeats[row].beat, DirectedBeats[row].fixed,
                   DirectedBeats[row].fixed_rsp);
      end
      // Let the pipeline empty completely once before the random part.
      wait_for_drain();

      beat_target = beats_accepted + RandomBeats;
      while (beats_accepted < beat_target) begin
         // Each episode picks its own idle pressure, often none at all.
         gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 20);
         stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 20);
         if ($urandom_range(0, 9) == 0) begin
            // Noise: loose table bytes and coded bits in any order.
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 1) == 1) begin
                  send_beat(bit_beat(1'($urandom_range(0, 1))), 1'b0, NoRsp);
               end else begin
                  send_beat(table_beat(8'($urandom), 1'($urandom_range(0, 1))),
                            1'b0, NoRsp);
               end
            end
         end else begin
            load_random_table();
            send_coded_bits($urandom_range(8, 80));
         end
         if (!tail_phase && $urandom_range(0, 7) == 0) wait_for_drain();
      end

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TimeoutNs);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
